// ===== rtl/hc_pkg.sv =====
package hc_pkg;

    localparam int WORD_W       = 63;
    localparam int PARITY_W     = 3;
    localparam int MAX_PARITY_D = 6;
    localparam int MIN_PARITY   = 2;
    localparam int RESET_PARITY = 3;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // control that rides along with each item through the pipe
    typedef struct packed {
        logic valid;
        logic decode;
    } hc_ctl_t;

    // position p (from 1) holds a parity bit
    function automatic bit is_pow2(input int p);
        begin
            return (p != 0) && ((p & (p - 1)) == 0);
        end
    endfunction

    // data bit index carried at non-parity position p
    function automatic int data_slot(input int p);
        int cnt;
        begin
            cnt = 0;
            for (int b = 0; b < 31; b++)
            begin
                if ((1 << b) <= p)
                begin
                    cnt++;
                end
            end
            return p - 1 - cnt;
        end
    endfunction

endpackage

// ===== rtl/hc_spread.sv =====
module hc_spread
    import hc_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_D
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hc_ctl_t                           ctl_in,
    input  logic [WORD_W-1:0]                 in_word,
    input  logic [PARITY_W-1:0]               r_cur,
    output hc_ctl_t                           ctl_out,
    output logic [(1 << MAX_PARITY)-2:0]      word_out
);

    localparam int CW_W = (1 << MAX_PARITY) - 1;

    logic [CW_W-1:0] enc_bits;
    logic [CW_W-1:0] pos_mask;
    logic [CW_W-1:0] word_next;
    logic [CW_W-1:0] word_reg;
    hc_ctl_t         ctl_reg;

    // data bits land on non-power-of-two positions; parity slots start at zero
    for (genvar j = 0; j < CW_W; j++)
    begin : g_pos
        localparam logic [MAX_PARITY-1:0] PV = MAX_PARITY'(j + 1);
        if (is_pow2(j + 1))
        begin : g_par
            assign enc_bits[j] = 1'b0;
        end
        else
        begin : g_dat
            assign enc_bits[j] = in_word[data_slot(j + 1)];
        end
        // position lies within n = 2^r - 1
        assign pos_mask[j] = ((PV >> r_cur) == '0);
    end

    assign word_next = (ctl_in.decode ? in_word[CW_W-1:0] : enc_bits) & pos_mask;

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign word_out = word_reg;

endmodule

// ===== rtl/hc_syndrome.sv =====
module hc_syndrome
    import hc_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_D
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hc_ctl_t                           ctl_in,
    input  logic [(1 << MAX_PARITY)-2:0]      word_in,
    output hc_ctl_t                           ctl_out,
    output logic [(1 << MAX_PARITY)-2:0]      word_out,
    output logic [MAX_PARITY-1:0]             syn_out
);

    localparam int CW_W = (1 << MAX_PARITY) - 1;

    logic [MAX_PARITY-1:0] syn_next;
    logic [MAX_PARITY-1:0] syn_reg;
    logic [CW_W-1:0]       word_reg;
    hc_ctl_t               ctl_reg;

    // XOR of the positions of all set bits; with parity slots clear this is
    // also the parity vector for encode
    always_comb
    begin
        syn_next = '0;
        for (int i = 0; i < MAX_PARITY; i++)
        begin
            for (int j = 0; j < CW_W; j++)
            begin
                if ((((j + 1) >> i) & 1) != 0)
                begin
                    syn_next[i] = syn_next[i] ^ word_in[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_in;
        syn_reg  <= syn_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign word_out = word_reg;
    assign syn_out  = syn_reg;

endmodule

// ===== rtl/hc_correct.sv =====
module hc_correct
    import hc_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_D
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hc_ctl_t                           ctl_in,
    input  logic [(1 << MAX_PARITY)-2:0]      word_in,
    input  logic [MAX_PARITY-1:0]             syn_in,
    output logic                              done,
    output logic [WORD_W-1:0]                 out_word,
    output logic                              corrected
);

    localparam int CW_W  = (1 << MAX_PARITY) - 1;
    localparam int DAT_W = CW_W - MAX_PARITY;

    logic [CW_W-1:0]   par_vec;
    logic [CW_W-1:0]   fixed;
    logic [DAT_W-1:0]  dec_data;
    logic              syn_nz;
    logic [WORD_W-1:0] out_word_next;
    logic [WORD_W-1:0] out_word_reg;
    logic              corrected_next;
    logic              corrected_reg;
    logic              done_reg;

    assign syn_nz = (syn_in != '0);

    for (genvar j = 0; j < CW_W; j++)
    begin : g_pos
        localparam logic [MAX_PARITY-1:0] PV = MAX_PARITY'(j + 1);
        // flip the bit the syndrome points at
        assign fixed[j] = word_in[j] ^ (syn_in == PV);
        if (is_pow2(j + 1))
        begin : g_par
            assign par_vec[j] = syn_in[$clog2(j + 1)];
        end
        else
        begin : g_dat
            assign par_vec[j] = 1'b0;
            assign dec_data[data_slot(j + 1)] = fixed[j];
        end
    end

    always_comb
    begin
        if (ctl_in.decode)
        begin
            out_word_next  = WORD_W'(dec_data);
            corrected_next = syn_nz;
        end
        else
        begin
            out_word_next  = WORD_W'(word_in | par_vec);
            corrected_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        corrected_reg <= corrected_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    assign done      = done_reg;
    assign out_word  = out_word_reg;
    assign corrected = corrected_reg;

endmodule

// ===== rtl/hamming_codec_configurable.sv =====
// Hamming SEC codec, three register stages: spread/mask, syndrome XOR tree,
// correct/extract into the output register.
// done pulses once the item has passed the spread, syndrome and output registers.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset (rst_n low, async): pipeline valid bits and done clear, parity_count
// returns to 3 (or MAX_PARITY if smaller). Payload registers are not reset.
module hamming_codec_configurable
    import hc_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_D
) (
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                start,
    output logic                busy,
    input  logic                action,
    input  logic [WORD_W-1:0]   in_word,
    // result strobe
    output logic                done,
    output logic [WORD_W-1:0]   out_word,
    output logic                corrected,
    // parity_count register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PARITY_W-1:0] parity_count
);

    localparam int CW_W = (1 << MAX_PARITY) - 1;
    localparam logic [PARITY_W-1:0] R_RESET =
        PARITY_W'((RESET_PARITY > MAX_PARITY) ? MAX_PARITY : RESET_PARITY);

    logic [PARITY_W-1:0] parity_count_reg;
    logic                cfg_ok;
    hc_ctl_t             in_ctl;
    hc_ctl_t             s1_ctl;
    hc_ctl_t             s2_ctl;
    logic [CW_W-1:0]     s1_word;
    logic [CW_W-1:0]     s2_word;
    logic [MAX_PARITY-1:0] s2_syn;

    // Fully pipelined: every stage moves each cycle, nothing to hold off.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Out-of-range writes are dropped; r keeps its value.
    assign cfg_ok = cfg_valid && cfg_ready
                 && (parity_count >= PARITY_W'(MIN_PARITY))
                 && (parity_count <= PARITY_W'(MAX_PARITY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_count_reg <= R_RESET;
        end
        else if (cfg_ok)
        begin
            parity_count_reg <= parity_count;
        end
    end

    // r only matters in the first stage (masking to n bits), so items
    // already in flight are unaffected by a later write.
    assign in_ctl.valid  = start && !busy;
    assign in_ctl.decode = (action == ACT_DECODE);

    // Stage 1: place data bits (encode) or take the codeword (decode), then mask to n bits.
    hc_spread #(
        .MAX_PARITY (MAX_PARITY)
    ) u_spread (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (in_ctl),
        .in_word  (in_word),
        .r_cur    (parity_count_reg),
        .ctl_out  (s1_ctl),
        .word_out (s1_word)
    );

    // Stage 2: syndrome; equals the parity bits when encoding.
    hc_syndrome #(
        .MAX_PARITY (MAX_PARITY)
    ) u_syndrome (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (s1_ctl),
        .word_in  (s1_word),
        .ctl_out  (s2_ctl),
        .word_out (s2_word),
        .syn_out  (s2_syn)
    );

    // Stage 3: insert parity, or flip the bad bit and pull the data out.
    hc_correct #(
        .MAX_PARITY (MAX_PARITY)
    ) u_correct (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (s2_ctl),
        .word_in   (s2_word),
        .syn_in    (s2_syn),
        .done      (done),
        .out_word  (out_word),
        .corrected (corrected)
    );

    // each accepted item comes out on done once it has passed the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("item did not complete in three cycles");

    // no result without a matching accepted item earlier in the pipeline
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without accepted item");

    // corrections only ever reported for decode items
    a_corr_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && corrected) |-> ($past(action, 3) == ACT_DECODE))
        else $error("correction flagged on encode");

    // parity count never leaves its legal range
    a_r_range: assert property (@(posedge clk) disable iff (!rst_n)
        (parity_count_reg >= PARITY_W'(MIN_PARITY))
        && (parity_count_reg <= PARITY_W'(MAX_PARITY)))
        else $error("parity count out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the configurable Hamming codec.
//
// A queue of pending items is filled by the sequencing initial block. The
// driver always block pops items from it, and at each accepted start it
// predicts the codec output under the current parity count and queues that
// prediction. The monitor always block pairs each done strobe with the oldest
// prediction. The parity count is written only while the codec is empty.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hc_pkg::*;

    // one item as the sender presents it
    typedef struct packed {
        logic              act;
        logic [WORD_W-1:0] word;
    } codec_item_t;

    // one result as the codec reports it
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              fixed;
    } codec_res_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic                action       = ACT_ENCODE;
    logic [WORD_W-1:0]   in_word      = '0;
    logic                done;
    logic [WORD_W-1:0]   out_word;
    logic                corrected;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [PARITY_W-1:0] parity_count = '0;

    codec_item_t pending_words[$];
    codec_res_t  due_results[$];

    // parity count the codec should hold right now
    int unsigned cur_parity = (RESET_PARITY > MAX_PARITY_D) ? MAX_PARITY_D : RESET_PARITY;
    // percent of cycles in which the sender holds start low
    int unsigned gap_pct    = 9;
    int unsigned fail_count = 0;

    hamming_codec_configurable DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .in_word      (in_word),
        .done         (done),
        .out_word     (out_word),
        .corrected    (corrected),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .parity_count (parity_count)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // XOR of the positions (from 1) of all set bits among the low n bits
    function automatic logic [6:0] syndrome_of(logic [WORD_W-1:0] w, int unsigned n);
        logic [6:0] syn;
        syn = '0;
        for (int unsigned p = 1; p <= n; p++)
        begin
            if (w[p-1])
            begin
                syn ^= 7'(p);
            end
        end
        return syn;
    endfunction

    function automatic codec_res_t hamming_codec_out(codec_item_t it, int unsigned r);
        int unsigned       n;
        int unsigned       di;
        logic [WORD_W-1:0] cw;
        logic [6:0]        syn;
        codec_res_t        res;
        n   = (1 << r) - 1;
        di  = 0;
        cw  = '0;
        res = '0;
        if (it.act == ACT_ENCODE)
        begin
            // data bits fill the non power-of-two positions, LSB first
            for (int unsigned p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    cw[p-1] = it.word[di];
                    di++;
                end
            end
            // parity slots are still zero, so syndrome bit i is exactly p_i
            syn = syndrome_of(cw, n);
            for (int unsigned i = 0; i < r; i++)
            begin
                cw[(1 << i) - 1] = syn[i];
            end
            res.word = cw;
        end
        else
        begin
            for (int unsigned p = 1; p <= n; p++)
            begin
                cw[p-1] = it.word[p-1];
            end
            syn = syndrome_of(cw, n);
            if (syn != '0)
            begin
                cw[int'(syn) - 1] = ~cw[int'(syn) - 1];
                res.fixed = 1'b1;
            end
            for (int unsigned p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    res.word[di] = cw[p-1];
                    di++;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: start is sampled at the edge together with busy; the next
    // item (or a gap) is set up at that same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                due_results.push_back(hamming_codec_out(pending_words[0], cur_parity));
                void'(pending_words.pop_front());
            end
            if (pending_words.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                start   <= 1'b1;
                action  <= pending_words[0].act;
                in_word <= pending_words[0].word;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done marks a result for exactly one cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        codec_res_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: out_word %h corrected %b", out_word, corrected);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (out_word !== want.word)
                begin
                    $error("out_word: expected %h, got %h", want.word, out_word);
                    fail_count++;
                end
                if (corrected !== want.fixed)
                begin
                    $error("corrected: expected %b, got %b", want.fixed, corrected);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'({$urandom, $urandom});
    endfunction

    // codeword of the given data under r, with position flip (from 1)
    // inverted; flip 0 leaves it clean
    function automatic logic [WORD_W-1:0] bad_codeword(logic [WORD_W-1:0] data,
                                                       int unsigned r, int unsigned flip);
        codec_item_t       src;
        logic [WORD_W-1:0] cw;
        src.act  = ACT_ENCODE;
        src.word = data;
        cw = hamming_codec_out(src, r).word;
        if (flip != 0)
        begin
            cw[flip-1] = ~cw[flip-1];
        end
        return cw;
    endfunction

    task automatic queue_item(logic act, logic [WORD_W-1:0] word);
        codec_item_t it;
        it.act  = act;
        it.word = word;
        pending_words.push_back(it);
    endtask

    // the sender holds off until every queued item has come back
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_words.size() != 0 || due_results.size() != 0);
    endtask

    // register write, only with the codec empty; out-of-range values must
    // leave the parity count unchanged
    task automatic write_parity(int unsigned v);
        wait_drained();
        @(posedge clk);
        cfg_valid    <= 1'b1;
        parity_count <= PARITY_W'(v);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (v >= MIN_PARITY && v <= MAX_PARITY_D)
        begin
            cur_parity = v;
        end
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned n;
        int unsigned pick;
        int unsigned flip;
        logic [WORD_W-1:0] w;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset parity count of 3 (7,4 code)
        @(negedge clk);
        queue_item(ACT_ENCODE, '0);
        queue_item(ACT_ENCODE, '1);                       // bits above k ignored
        queue_item(ACT_ENCODE, WORD_W'(4'b1011));
        queue_item(ACT_DECODE, '0);
        queue_item(ACT_DECODE, '1);                       // bits above n ignored
        queue_item(ACT_DECODE, bad_codeword(WORD_W'(4'b1011), 3, 0));
        queue_item(ACT_DECODE, bad_codeword(WORD_W'(4'b1011), 3, 1));   // parity bit hit
        queue_item(ACT_DECODE, bad_codeword(WORD_W'(4'b1011), 3, 4));
        queue_item(ACT_DECODE, bad_codeword(WORD_W'(4'b1011), 3, 7));   // top data bit hit

        // widest code
        write_parity(MAX_PARITY_D);
        queue_item(ACT_ENCODE, '1);
        queue_item(ACT_ENCODE, '0);
        queue_item(ACT_DECODE, '1);
        queue_item(ACT_DECODE, bad_codeword('1, MAX_PARITY_D, 63));
        queue_item(ACT_DECODE, bad_codeword(rand_word(), MAX_PARITY_D, 32));

        // narrowest code
        write_parity(MIN_PARITY);
        queue_item(ACT_ENCODE, WORD_W'(1));
        queue_item(ACT_ENCODE, '0);
        queue_item(ACT_DECODE, WORD_W'(3'b111));
        queue_item(ACT_DECODE, bad_codeword(WORD_W'(1), MIN_PARITY, 2));

        // out-of-range writes; parity count must stay at 2
        write_parity(0);
        write_parity(1);
        write_parity(7);
        queue_item(ACT_ENCODE, '1);
        queue_item(ACT_DECODE, '1);

        // random part: 35 batches of 50 items, the parity count written before
        // each batch; sender gaps 9%, then 68%, then none
        for (int b = 0; b < 35; b++)
        begin
            if (b < 5)
            begin
                write_parity(MIN_PARITY + b);
            end
            else
            begin
                write_parity($urandom_range(7));
            end
            gap_pct = (b < 12) ? 9 : (b < 24) ? 68 : 0;
            n = (1 << cur_parity) - 1;
            for (int i = 0; i < 50; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    queue_item(ACT_ENCODE, rand_word());
                end
                else if (pick < 85)
                begin
                    // well-formed codeword, mostly with one bit hit
                    flip = ($urandom_range(2) == 0) ? 0 : $urandom_range(n, 1);
                    w = bad_codeword(rand_word(), cur_parity, flip);
                    if ($urandom_range(3) == 0)
                    begin
                        // junk above the code length
                        w |= rand_word() & ~((WORD_W'(1) << n) - 1);
                    end
                    queue_item(ACT_DECODE, w);
                end
                else
                begin
                    queue_item(ACT_DECODE, rand_word());
                end
            end
        end

        wait_drained();
        // pipe is three stages deep; watch for stray strobes a little longer
        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d results never arrived", due_results.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hc_pkg.sv
rtl/hc_spread.sv
rtl/hc_syndrome.sv
rtl/hc_correct.sv
rtl/hamming_codec_configurable.sv
tb/sv/tb_top.sv
